### rtl/mpfd_pkg.sv
// Shared types, codes and constants of the page framebuffer draw engine.
package mpfd_pkg;

   localparam int WIDTH_PIXELS_DEF  = 128;
   localparam int HEIGHT_PIXELS_DEF = 64;
   localparam int QUEUE_DEPTH_DEF   = 4;

   localparam int OP_W      = 3;
   localparam int COORD_W   = 9;
   localparam int CALC_W    = COORD_W + 2;
   localparam int PATTERN_W = 8;
   localparam int MODE_W    = 2;
   localparam int DATA_W    = 8;
   // widest store: 128 columns by 16 pages
   localparam int ADDR_MAX_W = 11;
   localparam int COL_MAX_W  = 7;
   localparam int PAGE_MAX_W = 4;

   localparam logic [PATTERN_W-1:0] DOTTED_RESET = 8'h55;
   localparam logic [DATA_W-1:0]    MASK_ALL     = 8'hff;
   localparam logic [DATA_W-1:0]    MASK_ONE     = 8'h01;

   typedef enum logic [OP_W-1:0] {
      OP_PLOT  = 3'd0,
      OP_HLINE = 3'd1,
      OP_VLINE = 3'd2,
      OP_CLEAR = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_SET    = 2'd0,
      MODE_CLEAR  = 2'd1,
      MODE_TOGGLE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CMD_HLINE = 2'd0,
      CMD_VLINE = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_READ  = 2'd3
   } cmd_kind_type;

   // One queued command: a run of byte updates starting at addr.
   typedef struct packed {
      cmd_kind_type            kind;
      mode_type                mode;
      logic [ADDR_MAX_W-1:0]   addr;
      logic [ADDR_MAX_W-1:0]   count;      // bytes minus one
      logic [PATTERN_W-1:0]    pattern;
      logic [DATA_W-1:0]       first_mask; // row bit for hline, top page mask for vline
      logic [DATA_W-1:0]       last_mask;  // bottom page mask for vline
      logic                    zero_read;  // read off screen
   } cmd_type;

endpackage

### rtl/mpfd_front.sv
// Front end: classifies and clips one request into a byte-run command.
module mpfd_front import mpfd_pkg::*; #(
   parameter int WIDTH_PIXELS  = WIDTH_PIXELS_DEF,
   parameter int HEIGHT_PIXELS = HEIGHT_PIXELS_DEF
) (
   input  logic [OP_W-1:0]           operation,
   input  logic signed [COORD_W-1:0] x_pos,
   input  logic signed [COORD_W-1:0] y_pos,
   input  logic signed [COORD_W-1:0] length,
   input  logic [PATTERN_W-1:0]      pattern,
   input  logic [MODE_W-1:0]         draw_mode,
   input  logic [PATTERN_W-1:0]      dotted_pattern,
   output logic                      cmd_valid,
   output cmd_type                   cmd
);

   localparam int PAGE_COUNT  = (HEIGHT_PIXELS + 7) / 8;
   localparam int STORE_BYTES = WIDTH_PIXELS * PAGE_COUNT;
   localparam logic signed [CALC_W-1:0] W_S = CALC_W'(WIDTH_PIXELS);
   localparam logic signed [CALC_W-1:0] H_S = CALC_W'(HEIGHT_PIXELS);
   localparam logic signed [CALC_W-1:0] ZERO_S = '0;
   localparam logic signed [CALC_W-1:0] ONE_S  = CALC_W'(1);
   localparam logic [ADDR_MAX_W-1:0] W_A = ADDR_MAX_W'(WIDTH_PIXELS);

   logic signed [CALC_W-1:0] x_s, y_s, len_s;
   logic x_on, y_on;
   logic signed [CALC_W-1:0] h_start, h_end_raw, h_end, h_cnt;
   logic signed [CALC_W-1:0] v_sum, v_top_raw, v_bot_raw, v_top, v_bot, v_last;
   logic h_ok, v_ok;
   logic [PAGE_MAX_W-1:0] y_page, top_page, last_page;

   assign x_s   = {{2{x_pos[COORD_W-1]}}, x_pos};
   assign y_s   = {{2{y_pos[COORD_W-1]}}, y_pos};
   assign len_s = {{2{length[COORD_W-1]}}, length};

   assign x_on = (x_s >= ZERO_S) && (x_s < W_S);
   assign y_on = (y_s >= ZERO_S) && (y_s < H_S);

   // horizontal clip
   assign h_start   = (x_s < ZERO_S) ? ZERO_S : x_s;
   assign h_end_raw = x_s + len_s;
   assign h_end     = (h_end_raw > W_S) ? W_S : h_end_raw;
   assign h_cnt     = h_end - h_start - ONE_S;
   assign h_ok      = y_on && (h_end > h_start);

   // vertical clip, negative height draws upward
   assign v_sum     = y_s + len_s;
   assign v_top_raw = len_s[CALC_W-1] ? v_sum : y_s;
   assign v_bot_raw = len_s[CALC_W-1] ? y_s : v_sum;
   assign v_top     = (v_top_raw < ZERO_S) ? ZERO_S : v_top_raw;
   assign v_bot     = (v_bot_raw > H_S) ? H_S : v_bot_raw;
   assign v_last    = v_bot - ONE_S;
   assign v_ok      = x_on && (v_bot > v_top);

   assign y_page    = y_s[PAGE_MAX_W+2:3];
   assign top_page  = v_top[PAGE_MAX_W+2:3];
   assign last_page = v_last[PAGE_MAX_W+2:3];

   always_comb begin
      cmd       = '0;
      cmd_valid = 1'b0;
      case (op_type'(operation))
         OP_PLOT: begin
            cmd_valid      = x_on && y_on;
            cmd.kind       = CMD_HLINE;
            cmd.mode       = mode_type'(draw_mode);
            cmd.addr       = ADDR_MAX_W'(y_page) * W_A + ADDR_MAX_W'(x_s[COL_MAX_W-1:0]);
            cmd.pattern    = MASK_ONE;
            cmd.first_mask = MASK_ONE << y_s[2:0];
         end
         OP_HLINE: begin
            cmd_valid      = h_ok;
            cmd.kind       = CMD_HLINE;
            cmd.mode       = mode_type'(draw_mode);
            cmd.addr       = ADDR_MAX_W'(y_page) * W_A
                           + ADDR_MAX_W'(h_start[COL_MAX_W-1:0]);
            cmd.count      = ADDR_MAX_W'(h_cnt);
            cmd.pattern    = pattern;
            cmd.first_mask = MASK_ONE << y_s[2:0];
         end
         OP_VLINE: begin
            cmd_valid      = v_ok;
            cmd.kind       = CMD_VLINE;
            cmd.mode       = MODE_TOGGLE;
            cmd.addr       = ADDR_MAX_W'(top_page) * W_A + ADDR_MAX_W'(x_s[COL_MAX_W-1:0]);
            cmd.count      = ADDR_MAX_W'(last_page - top_page);
            // dotted pattern flips phase on an even start row
            cmd.pattern    = (pattern == dotted_pattern && !v_top[0]) ? ~pattern : pattern;
            cmd.first_mask = MASK_ALL << v_top[2:0];
            cmd.last_mask  = MASK_ALL >> (3'd7 - v_last[2:0]);
         end
         OP_CLEAR: begin
            cmd_valid = 1'b1;
            cmd.kind  = CMD_CLEAR;
            cmd.mode  = MODE_CLEAR;
            cmd.count = ADDR_MAX_W'(STORE_BYTES - 1);
         end
         OP_READ: begin
            cmd_valid     = 1'b1;
            cmd.kind      = CMD_READ;
            cmd.zero_read = !(x_on && y_on);
            if (x_on && y_on) begin
               cmd.addr = ADDR_MAX_W'(y_page) * W_A + ADDR_MAX_W'(x_s[COL_MAX_W-1:0]);
            end
         end
         default: begin
            cmd_valid = 1'b0;
         end
      endcase
   end

endmodule

### rtl/mpfd_queue.sv
// Short command queue between the front end and the draw engine.
module mpfd_queue import mpfd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/mpfd_back.sv
// Draw engine: walks byte runs through read-modify-write of the page store.
module mpfd_back import mpfd_pkg::*; #(
   parameter int WIDTH_PIXELS  = WIDTH_PIXELS_DEF,
   parameter int HEIGHT_PIXELS = HEIGHT_PIXELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   output logic              init_busy,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [DATA_W-1:0] rsp_read_data
);

   localparam int PAGE_COUNT  = (HEIGHT_PIXELS + 7) / 8;
   localparam int STORE_BYTES = WIDTH_PIXELS * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam logic [ADDR_MAX_W-1:0] W_A        = ADDR_MAX_W'(WIDTH_PIXELS);
   localparam logic [ADDR_MAX_W-1:0] STORE_LAST = ADDR_MAX_W'(STORE_BYTES - 1);

   typedef enum logic [2:0] {
      ST_INIT = 3'b001,
      ST_IDLE = 3'b010,
      ST_RUN  = 3'b100
   } state_type;

   function automatic logic [DATA_W-1:0] apply_mode(input logic [DATA_W-1:0] data,
                                                    input logic [DATA_W-1:0] mask,
                                                    input mode_type mode);
      logic [DATA_W-1:0] res;
      case (mode)
         MODE_SET:   res = data | mask;
         MODE_CLEAR: res = data & ~mask;
         default:    res = data ^ mask;
      endcase
      return res;
   endfunction

   logic [DATA_W-1:0] store_mem [STORE_BYTES];
   logic [DATA_W-1:0] rd_data_ff;

   state_type             state_ff, state_in;
   cmd_kind_type          kind_ff, kind_in;
   mode_type              mode_ff, mode_in;
   logic [ADDR_MAX_W-1:0] addr_ff, addr_in;
   logic [ADDR_MAX_W-1:0] count_ff, count_in;
   logic [PATTERN_W-1:0]  pattern_ff, pattern_in;
   logic [DATA_W-1:0]     first_mask_ff, first_mask_in;
   logic [DATA_W-1:0]     last_mask_ff, last_mask_in;
   logic                  zero_read_ff, zero_read_in;
   logic                  first_ff, first_in;

   // write-back stage, working in the cycle after the store read
   logic                  wr_valid_ff, wr_valid_in;
   logic [ADDR_MAX_W-1:0] wr_addr_ff;
   logic [DATA_W-1:0]     wr_mask_ff, step_mask;
   mode_type              wr_mode_ff;
   logic                  rd_pend_ff, rd_pend_in;
   logic                  rd_zero_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_data_ff;

   logic step_go, last_step, read_free, load;

   assign step_go   = (state_ff == ST_INIT) || (state_ff == ST_RUN);
   assign last_step = (count_ff == '0);
   assign read_free = !rsp_valid_ff && !rd_pend_ff;
   assign load      = (state_ff == ST_IDLE) && !cmd_empty
                    && ((cmd.kind != CMD_READ) || read_free);
   assign cmd_pop   = load;
   assign init_busy = (state_ff == ST_INIT);

   assign rsp_empty     = !rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   always_comb begin
      case (kind_ff)
         CMD_HLINE: step_mask = pattern_ff[0] ? first_mask_ff : '0;
         CMD_VLINE: step_mask = pattern_ff
                              & (first_ff ? first_mask_ff : MASK_ALL)
                              & (last_step ? last_mask_ff : MASK_ALL);
         CMD_CLEAR: step_mask = MASK_ALL;
         default:   step_mask = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      mode_in       = mode_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      pattern_in    = pattern_ff;
      first_mask_in = first_mask_ff;
      last_mask_in  = last_mask_ff;
      zero_read_in  = zero_read_ff;
      first_in      = first_ff;
      wr_valid_in   = step_go && (kind_ff != CMD_READ);
      rd_pend_in    = step_go && (kind_ff == CMD_READ);
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
      if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
      end

      if (load) begin
         state_in      = ST_RUN;
         kind_in       = cmd.kind;
         mode_in       = cmd.mode;
         addr_in       = cmd.addr;
         count_in      = cmd.count;
         pattern_in    = cmd.pattern;
         first_mask_in = cmd.first_mask;
         last_mask_in  = cmd.last_mask;
         zero_read_in  = cmd.zero_read;
         first_in      = 1'b1;
      end else if (step_go) begin
         first_in   = 1'b0;
         count_in   = count_ff - 1'b1;
         addr_in    = (kind_ff == CMD_VLINE) ? addr_ff + W_A : addr_ff + 1'b1;
         pattern_in = (kind_ff == CMD_HLINE) ? {pattern_ff[0], pattern_ff[PATTERN_W-1:1]}
                                             : pattern_ff;
         if (last_step) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         kind_ff      <= CMD_CLEAR;
         mode_ff      <= MODE_CLEAR;
         addr_ff      <= '0;
         count_ff     <= STORE_LAST;
         wr_valid_ff  <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         mode_ff      <= mode_in;
         addr_ff      <= addr_in;
         count_ff     <= count_in;
         wr_valid_ff  <= wr_valid_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pattern_ff    <= pattern_in;
      first_mask_ff <= first_mask_in;
      last_mask_ff  <= last_mask_in;
      zero_read_ff  <= zero_read_in;
      first_ff      <= first_in;
      wr_addr_ff    <= addr_ff;
      wr_mask_ff    <= step_mask;
      wr_mode_ff    <= mode_ff;
      rd_zero_ff    <= zero_read_ff;
      if (rd_pend_ff) begin
         rsp_data_ff <= rd_zero_ff ? '0 : rd_data_ff;
      end
   end

   // page store: read one byte, write back the previous one
   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[addr_ff[ADDR_W-1:0]];
      if (wr_valid_ff) begin
         store_mem[wr_addr_ff[ADDR_W-1:0]] <= apply_mode(rd_data_ff, wr_mask_ff, wr_mode_ff);
      end
   end

endmodule

### rtl/mono_page_framebuffer_draw.sv
// Top level of the monochrome page framebuffer draw engine.
//
// Draw engine for a 1-bit display store kept in pages: each byte holds eight
// vertical pixels of one column, bit 0 on top, byte of page p and column c at
// p*WIDTH_PIXELS+c. A request is plot, horizontal stippled line, vertical
// stippled line (always toggles), clear all, or read one byte; only a read
// gives a response. Requests go into a QUEUE_DEPTH-entry command queue after
// clipping, so firmware can post several draws ahead; req_full rises when it
// fills. The engine updates the store one byte per cycle through a
// read-modify-write pipe on its single-write, single-read memory: a
// horizontal line writes one byte per visible column, a vertical line one
// byte per page it touches, a plot one byte, clear all every byte of the
// store, and a read starts once the response register is free. Requests
// that draw nothing are taken and dropped at once. After reset the engine
// sweeps the whole store to zero, one byte per cycle, holding req_full
// high meanwhile; csr writes are taken at any time.
module mono_page_framebuffer_draw import mpfd_pkg::*; #(
   parameter int WIDTH_PIXELS  = WIDTH_PIXELS_DEF,
   parameter int HEIGHT_PIXELS = HEIGHT_PIXELS_DEF,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request side
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [OP_W-1:0]           req_operation,
   input  logic signed [COORD_W-1:0] req_x_pos,
   input  logic signed [COORD_W-1:0] req_y_pos,
   input  logic signed [COORD_W-1:0] req_length,
   input  logic [PATTERN_W-1:0]      req_pattern,
   input  logic [MODE_W-1:0]         req_draw_mode,
   // response side
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [DATA_W-1:0]         rsp_read_data,
   // dotted pattern register
   input  logic                      csr_wr_en,
   input  logic [PATTERN_W-1:0]      csr_wr_data
);

   logic [PATTERN_W-1:0] dotted_pattern_ff;
   logic    front_valid;
   cmd_type front_cmd;
   logic    queue_full, queue_empty, queue_pop;
   cmd_type head_cmd;
   logic    init_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         dotted_pattern_ff <= DOTTED_RESET;
      end else if (csr_wr_en) begin
         dotted_pattern_ff <= csr_wr_data;
      end
   end

   // no request gets in during the reset clearing sweep
   assign req_full = queue_full || init_busy;

   mpfd_front #(
      .WIDTH_PIXELS  (WIDTH_PIXELS),
      .HEIGHT_PIXELS (HEIGHT_PIXELS)
   ) u_front (
      .operation      (req_operation),
      .x_pos          (req_x_pos),
      .y_pos          (req_y_pos),
      .length         (req_length),
      .pattern        (req_pattern),
      .draw_mode      (req_draw_mode),
      .dotted_pattern (dotted_pattern_ff),
      .cmd_valid      (front_valid),
      .cmd            (front_cmd)
   );

   mpfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push && !req_full && front_valid),
      .push_cmd (front_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty)
   );

   mpfd_back #(
      .WIDTH_PIXELS  (WIDTH_PIXELS),
      .HEIGHT_PIXELS (HEIGHT_PIXELS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_empty     (queue_empty),
      .cmd           (head_cmd),
      .cmd_pop       (queue_pop),
      .init_busy     (init_busy),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_read_data (rsp_read_data)
   );

endmodule

### tb/tb_mono_page_framebuffer_draw.sv
// Self-checking testbench for the monochrome page framebuffer draw engine.
`timescale 1ns / 1ps

module tb_mono_page_framebuffer_draw;
   import mpfd_pkg::*;

   // Geometry matches the block's default parameters.
   localparam int WIDTH       = WIDTH_PIXELS_DEF;
   localparam int HEIGHT      = HEIGHT_PIXELS_DEF;
   localparam int STORE_BYTES = WIDTH * ((HEIGHT + 7) / 8);

   // Codes the package leaves unnamed: operations the block ignores and the
   // fourth draw mode, which behaves as toggle.
   localparam logic [OP_W-1:0]   OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0]   OP_UNUSED_HI = 3'd7;
   localparam logic [MODE_W-1:0] MODE_THREE   = 2'd3;

   // Worst drain: a full command queue of clear-all commands plus the one
   // the engine is working on.
   localparam int SETTLE_CYCLES  = (QUEUE_DEPTH_DEF + 1) * (STORE_BYTES + 16);
   // Cycles with no request and no response accepted before giving up.
   localparam int WATCHDOG_LIMIT = 10 * SETTLE_CYCLES;

   typedef struct {
      logic [OP_W-1:0]           op;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] len;
      logic [PATTERN_W-1:0]      pat;
      logic [MODE_W-1:0]         mode;
   } draw_req_type;

   // Mirror of the frame store plus the read bytes still owed by the block.
   class frame_scoreboard_type;
      logic [DATA_W-1:0]    pixels [STORE_BYTES];
      logic [PATTERN_W-1:0] dotted;
      logic [DATA_W-1:0]    readback_q [$];
      int                   failures;

      function new();
         dotted   = DOTTED_RESET;
         failures = 0;
         wipe();
      endfunction

      function void wipe();
         foreach (pixels[i]) pixels[i] = '0;
      endfunction

      function void touch(int col, int row, logic [MODE_W-1:0] mode);
         int                idx;
         logic [DATA_W-1:0] bit_mask;
         idx      = (row / 8) * WIDTH + col;
         bit_mask = MASK_ONE << (row % 8);
         if (idx < 0 || idx >= STORE_BYTES) return;
         case (mode)
            MODE_SET:   pixels[idx] = pixels[idx] | bit_mask;
            MODE_CLEAR: pixels[idx] = pixels[idx] & ~bit_mask;
            default:    pixels[idx] = pixels[idx] ^ bit_mask;
         endcase
      endfunction

      // Apply one accepted request to the mirror; a read queues its byte.
      function void note_request(draw_req_type r);
         int                   x, y, len, first, last;
         logic [PATTERN_W-1:0] pat;
         x   = r.x;
         y   = r.y;
         len = r.len;
         pat = r.pat;
         case (r.op)
            OP_PLOT: begin
               if (x >= 0 && x < WIDTH && y >= 0 && y < HEIGHT) touch(x, y, r.mode);
            end
            OP_HLINE: begin
               if (y >= 0 && y < HEIGHT) begin
                  first = (x < 0) ? 0 : x;
                  last  = x + len;
                  if (last > WIDTH) last = WIDTH;
                  // pattern starts at the first visible column, rotates right
                  for (int c = first; c < last; c++) begin
                     if (pat[0]) touch(c, y, r.mode);
                     pat = {pat[0], pat[PATTERN_W-1:1]};
                  end
               end
            end
            OP_VLINE: begin
               if (x >= 0 && x < WIDTH) begin
                  if (len < 0) begin
                     first = y + len;
                     last  = y;
                  end else begin
                     first = y;
                     last  = y + len;
                  end
                  if (first < 0) first = 0;
                  if (last > HEIGHT) last = HEIGHT;
                  if (last > first) begin
                     if (pat == dotted && (first % 2) == 0) pat = ~pat;
                     for (int row = first; row < last; row++)
                        if (pat[row % 8]) touch(x, row, MODE_TOGGLE);
                  end
               end
            end
            OP_CLEAR: wipe();
            OP_READ: begin
               if (x >= 0 && x < WIDTH && y >= 0 && y < HEIGHT)
                  readback_q.push_back(pixels[(y / 8) * WIDTH + x]);
               else
                  readback_q.push_back('0);
            end
            default: ;
         endcase
      endfunction

      function void check_readback(logic [DATA_W-1:0] got);
         logic [DATA_W-1:0] want;
         if (readback_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected read response: rsp_read_data=%02h", got);
            return;
         end
         want = readback_q.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10)
               $display("read_data mismatch: expected %02h actual %02h", want, got);
         end
      endfunction
   endclass

   // Every input starts at a known value.
   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      req_push      = 1'b0;
   logic                      req_full;
   logic [OP_W-1:0]           req_operation = '0;
   logic signed [COORD_W-1:0] req_x_pos     = '0;
   logic signed [COORD_W-1:0] req_y_pos     = '0;
   logic signed [COORD_W-1:0] req_length    = '0;
   logic [PATTERN_W-1:0]      req_pattern   = '0;
   logic [MODE_W-1:0]         req_draw_mode = '0;
   logic                      rsp_empty;
   logic                      rsp_pop       = 1'b0;
   logic [DATA_W-1:0]         rsp_read_data;
   logic                      csr_wr_en     = 1'b0;
   logic [PATTERN_W-1:0]      csr_wr_data   = '0;

   frame_scoreboard_type sb;
   int send_idle_pct = 9;   // percent of cycles the request side holds off
   int recv_idle_pct = 81;  // percent of cycles the response side stalls
   int quiet_cycles  = 0;

   mono_page_framebuffer_draw dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_x_pos     (req_x_pos),
      .req_y_pos     (req_y_pos),
      .req_length    (req_length),
      .req_pattern   (req_pattern),
      .req_draw_mode (req_draw_mode),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_read_data (rsp_read_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Response side: check on accept, then pick next cycle's pop. The watchdog
   // rides along and counts edges where neither side moved anything.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) sb.check_readback(rsp_read_data);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic draw_req_type make_request(logic [OP_W-1:0] op, int x, int y, int len,
                                                 int pat, logic [MODE_W-1:0] mode);
      draw_req_type r;
      r.op   = op;
      r.x    = COORD_W'(x);
      r.y    = COORD_W'(y);
      r.len  = COORD_W'(len);
      r.pat  = PATTERN_W'(pat);
      r.mode = mode;
      return r;
   endfunction

   // Mostly on screen, now and then anywhere from -128 to 255.
   function automatic logic signed [COORD_W-1:0] pick_coord(int lim);
      if ($urandom_range(99) < 85) return COORD_W'($urandom_range(lim - 1));
      return COORD_W'($urandom_range(383) - 128);
   endfunction

   function automatic draw_req_type random_request(logic [PATTERN_W-1:0] dotted);
      draw_req_type r;
      int           pick;
      pick   = $urandom_range(99);
      r.x    = pick_coord(WIDTH);
      r.y    = pick_coord(HEIGHT);
      r.pat  = ($urandom_range(7) == 0) ? MASK_ALL : PATTERN_W'($urandom_range(255));
      r.mode = ($urandom_range(19) == 0) ? MODE_THREE : MODE_W'($urandom_range(MODE_TOGGLE));
      r.len  = COORD_W'($urandom_range(383) - 128);
      if (pick < 22) begin
         r.op = OP_PLOT;
      end else if (pick < 44) begin
         r.op = OP_HLINE;
         // short lines keep the run quick; the full range stays in the mix
         if ($urandom_range(99) < 80) r.len = COORD_W'($urandom_range(40, 1));
      end else if (pick < 66) begin
         r.op = OP_VLINE;
         if ($urandom_range(99) < 80) r.len = COORD_W'($urandom_range(40) - 20);
         if ($urandom_range(99) < 35) r.pat = dotted;
      end else if (pick < 67) begin
         r.op = OP_CLEAR;
      end else if (pick < 69) begin
         r.op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      end else begin
         r.op = OP_READ;
      end
      return r;
   endfunction

   // Hold off at random, then present the request until the block takes it.
   task automatic send_request(draw_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_operation <= r.op;
      req_x_pos     <= r.x;
      req_y_pos     <= r.y;
      req_length    <= r.len;
      req_pattern   <= r.pat;
      req_draw_mode <= r.mode;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_request(r);
   endtask

   // All reads answered, then enough time for queued draws to finish.
   task automatic wait_idle();
      while (sb.readback_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_dotted(logic [PATTERN_W-1:0] value);
      req_push <= 1'b0;
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.dotted = value;
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) send_request(random_request(sb.dotted));
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part, dotted pattern at its reset value.
      // Plots at the corners, off-screen plots that must be dropped, and
      // toggle / clear / mode three on the top page.
      send_request(make_request(OP_PLOT, 0, 0, 0, 0, MODE_SET));
      send_request(make_request(OP_PLOT, 127, 63, 0, 0, MODE_SET));
      send_request(make_request(OP_PLOT, 128, 5, 0, 0, MODE_SET));
      send_request(make_request(OP_PLOT, -128, -128, 0, 0, MODE_SET));
      send_request(make_request(OP_PLOT, 5, 64, 0, 0, MODE_SET));
      send_request(make_request(OP_PLOT, 0, 1, 0, 0, MODE_TOGGLE));
      send_request(make_request(OP_PLOT, 0, 2, 0, 0, MODE_THREE));
      send_request(make_request(OP_PLOT, 0, 0, 0, 0, MODE_CLEAR));
      send_request(make_request(OP_READ, 0, 7, 0, 0, MODE_SET));
      send_request(make_request(OP_READ, 127, 56, 0, 0, MODE_SET));
      // Horizontal lines: clipped on the left, clipped on the right, negative
      // width, row off screen, start past the last column.
      send_request(make_request(OP_HLINE, -128, 12, 255, 8'ha5, MODE_SET));
      send_request(make_request(OP_HLINE, 100, 13, 255, 8'h3c, MODE_TOGGLE));
      send_request(make_request(OP_HLINE, 10, 14, -128, MASK_ALL, MODE_SET));
      send_request(make_request(OP_HLINE, 0, -1, 50, MASK_ALL, MODE_SET));
      send_request(make_request(OP_HLINE, 255, 20, 10, MASK_ALL, MODE_SET));
      // Vertical lines: dotted pattern from an even clipped top (inverted) and
      // from an odd top, negative height, column off screen, empty heights.
      send_request(make_request(OP_VLINE, 3, 10, -128, DOTTED_RESET, MODE_SET));
      send_request(make_request(OP_VLINE, 4, 63, 255, DOTTED_RESET, MODE_CLEAR));
      send_request(make_request(OP_VLINE, 5, 20, -3, MASK_ALL, MODE_SET));
      send_request(make_request(OP_VLINE, 128, 0, 10, MASK_ALL, MODE_SET));
      send_request(make_request(OP_VLINE, 6, 64, 5, MASK_ALL, MODE_SET));
      send_request(make_request(OP_VLINE, 6, 10, 0, MASK_ALL, MODE_SET));
      send_request(make_request(OP_READ, 3, 0, 0, 0, MODE_SET));
      send_request(make_request(OP_READ, 4, 60, 0, 0, MODE_SET));
      send_request(make_request(OP_READ, 255, -128, 0, 0, MODE_SET));
      // Ignored codes, then clear everything and read back.
      send_request(make_request(OP_UNUSED_LO, 0, 0, 0, MASK_ALL, MODE_SET));
      send_request(make_request(OP_UNUSED_HI, 0, 0, 0, MASK_ALL, MODE_SET));
      send_request(make_request(OP_CLEAR, 0, 0, 0, 0, MODE_SET));
      send_request(make_request(OP_READ, 5, 16, 0, 0, MODE_SET));

      // Random part, one dotted setting per stretch. Sender mostly busy,
      // receiver mostly stalled; then the reverse; then no idling at all.
      write_dotted('0);
      run_random(609);

      write_dotted(MASK_ALL);
      send_idle_pct = 81;
      recv_idle_pct = 9;
      run_random(609);

      write_dotted(PATTERN_W'($urandom_range(255)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(304);

      write_dotted(8'haa);
      run_random(304);

      req_push <= 1'b0;
      wait_idle();
      sb.failures += sb.readback_q.size();
      if (sb.failures == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
